>>> hdl/xor_linked_deque_top_defines.svh
// Assertion macros shared by the deque checker.
// No dependencies; included by hdl/xld_checker.sv.
`ifndef XOR_LINKED_DEQUE_TOP_DEFINES_SVH
`define XOR_LINKED_DEQUE_TOP_DEFINES_SVH

// same-cycle implication, checking held off while reset is low
`define XLD_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("xld check failed");

// next-cycle implication, checking held off while reset is low
`define XLD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("xld check failed");

`endif

>>> hdl/xld_pkg.sv
// Shared types and constants for the XOR-linked deque.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps

package xld_pkg;

  // node pool; slot 0 is the null link
  localparam int SLOTS       = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int WORD_BITS   = 32;

  // fixed port field widths
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // result word layout, lowest bit up
  localparam int OUT_EMPTY_BIT = DATA_W;
  localparam int OUT_COUNT_LSB = DATA_W + 1;
  localparam int OUT_COUNT_MSB = OUT_COUNT_LSB + COUNT_W - 1;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_COUNT_MSB - 1;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_HEAD = 2'd0,
    MODE_PUSH_TAIL = 2'd1,
    MODE_POP_HEAD  = 2'd2,
    MODE_POP_TAIL  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // decoded request as held in the queue
  typedef struct packed {
    logic                 is_pop;
    logic                 at_head;
    logic [WORD_BITS-1:0] word;
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH_FIX,
    S_POP_NB,
    S_POP_FIX
  } ctl_state_t;

endpackage

>>> hdl/xor_linked_deque_top.sv
// Top level of the XOR-linked deque: front end, request queue and back end.
// Depends on xld_pkg, xld_front and xld_back.
`timescale 1ns / 1ps

// Double-ended queue of 32-bit words held as an XOR-linked list in a pool of
// 15 usable node slots (slot 0 is null). Each request is a push or pop at the
// head or tail; every request gives exactly one result carrying the popped
// word, a status, an empty flag and the entry count. Requests enter a two-deep
// queue and are run one at a time by the back end: a push into a non-empty
// list writes the new node, then rewrites the old end's link; an error or a
// push into an empty list finishes at once. The link memory gives one
// registered read per cycle, so a pop must read the end link, then the
// neighbour link, before rewriting it. The result sits in an output register;
// the back end waits only when that register is still unread.
// No clearing pass after reset; the block takes requests at once.

module xor_linked_deque_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [xld_pkg::IN_TDATA_W-1:0]  in_tdata,   // data_in[31:0]
  input  logic [xld_pkg::MODE_W-1:0]      in_tuser,   // mode[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // data_out[31:0], list_empty[32], entry_count[36:33], zero pad[39:37]
  output logic [xld_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [xld_pkg::STATUS_W-1:0]    out_tuser   // status[1:0]
);
  import xld_pkg::*;

  logic q_valid;
  logic q_pop;
  op_t  q_item;

  xld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  xld_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> hdl/xld_front.sv
// Front end: takes input requests, decodes the mode and queues them.
// Depends on xld_pkg.
`timescale 1ns / 1ps

module xld_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [xld_pkg::IN_TDATA_W-1:0] in_tdata,  // data_in
  input  logic [xld_pkg::MODE_W-1:0]    in_tuser,  // mode
  output logic                          q_valid,
  output xld_pkg::op_t                  q_item,
  input  logic                          q_pop
);
  import xld_pkg::*;

  op_t               q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  mode_t             mode;
  op_t               dec;

  // decode the request
  assign mode        = mode_t'(in_tuser);
  assign dec.is_pop  = (mode == MODE_POP_HEAD) || (mode == MODE_POP_TAIL);
  assign dec.at_head = (mode == MODE_PUSH_HEAD) || (mode == MODE_POP_HEAD);
  assign dec.word    = WORD_BITS'(in_tdata);

  assign in_tready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> hdl/xld_back.sv
// Back end: runs each queued request against the node pool, link and value
// memories and the free stack, and holds the result register. Depends on xld_pkg.
`timescale 1ns / 1ps

module xld_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  xld_pkg::op_t                    q_item,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [xld_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [xld_pkg::STATUS_W-1:0]    out_tuser
);
  import xld_pkg::*;

  // memories, registered read
  logic [SLOT_W-1:0]    link_mem [SLOTS];
  logic [WORD_BITS-1:0] value_mem [SLOTS];
  logic [SLOT_W-1:0]    link_rd_r;
  logic [WORD_BITS-1:0] value_rd_r;

  // free stack, reset holds slots 1 upward with slot 1 on top
  logic [SLOT_W-1:0] free_stk_r [SLOTS-1];
  logic [SLOT_W-1:0] free_cnt_r, free_cnt_nxt;

  ctl_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [SLOT_W-1:0] node_r, node_nxt;
  logic [SLOT_W-1:0] nbr_r, nbr_nxt;
  logic              at_head_r, at_head_nxt;

  // result register
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_data_r;
  status_t              out_status_r;
  logic                 out_empty_r;
  logic [COUNT_W-1:0]   out_count_r;

  // memory and stack controls
  logic                 link_we, link_re, val_we, val_re, stk_we;
  logic [SLOT_W-1:0]    link_waddr, link_wdata, link_raddr;
  logic [SLOT_W-1:0]    val_addr, stk_waddr, stk_wdata;
  logic                 res_load;
  status_t              res_status;
  logic [WORD_BITS-1:0] res_word;
  logic [SLOT_W-1:0]    res_left;

  // shared decisions
  logic              out_free, list_empty, pool_full, idle_err, idle_short, idle_go;
  logic [SLOT_W-1:0] free_top, end_slot;

  assign out_free   = !out_valid_r || out_tready;
  assign list_empty = (head_r == '0);
  assign pool_full  = (free_cnt_r == '0);
  assign free_top   = free_stk_r[free_cnt_r - 1'b1];
  assign end_slot   = q_item.at_head ? head_r : tail_r;
  assign idle_err   = q_item.is_pop ? list_empty : pool_full;
  // an error or a push into an empty list finishes without leaving S_IDLE
  assign idle_short = idle_err || (!q_item.is_pop && list_empty);
  assign idle_go    = (state_r == S_IDLE) && q_valid && (!idle_short || out_free);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (idle_go && !idle_short) begin
          state_nxt = q_item.is_pop ? S_POP_NB : S_PUSH_FIX;
        end
      end
      S_PUSH_FIX: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_POP_NB: begin
        if (link_rd_r != '0) begin
          state_nxt = S_POP_FIX;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_POP_FIX: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls per state
  always_comb begin
    q_pop        = 1'b0;
    link_we      = 1'b0;
    link_waddr   = '0;
    link_wdata   = '0;
    link_re      = 1'b0;
    link_raddr   = '0;
    val_we       = 1'b0;
    val_re       = 1'b0;
    val_addr     = '0;
    stk_we       = 1'b0;
    stk_waddr    = free_cnt_r;
    stk_wdata    = node_r;
    free_cnt_nxt = free_cnt_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    node_nxt     = node_r;
    nbr_nxt      = nbr_r;
    at_head_nxt  = at_head_r;
    res_load     = 1'b0;
    res_status   = ST_DONE;
    res_word     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (idle_go) begin
          q_pop       = 1'b1;
          at_head_nxt = q_item.at_head;
          if (idle_err) begin
            res_load   = 1'b1;
            res_status = q_item.is_pop ? ST_EMPTY : ST_FULL;
          end else if (!q_item.is_pop) begin
            // take a slot, store the word, link it to the old end
            free_cnt_nxt = free_cnt_r - 1'b1;
            node_nxt     = free_top;
            nbr_nxt      = end_slot;
            val_we       = 1'b1;
            val_addr     = free_top;
            link_we      = 1'b1;
            link_waddr   = free_top;
            link_wdata   = end_slot;
            if (list_empty) begin
              head_nxt = free_top;
              tail_nxt = free_top;
              res_load = 1'b1;
            end else begin
              link_re    = 1'b1;
              link_raddr = end_slot;
            end
          end else begin
            // fetch the end node's link and word
            node_nxt   = end_slot;
            link_re    = 1'b1;
            link_raddr = end_slot;
            val_re     = 1'b1;
            val_addr   = end_slot;
          end
        end
      end
      S_PUSH_FIX: begin
        if (out_free) begin
          link_we    = 1'b1;
          link_waddr = nbr_r;
          link_wdata = link_rd_r ^ node_r;
          if (at_head_r) head_nxt = node_r;
          else           tail_nxt = node_r;
          res_load = 1'b1;
        end
      end
      S_POP_NB: begin
        if (link_rd_r != '0) begin
          nbr_nxt    = link_rd_r;
          link_re    = 1'b1;
          link_raddr = link_rd_r;
        end else if (out_free) begin
          // last entry leaves
          head_nxt     = '0;
          tail_nxt     = '0;
          stk_we       = 1'b1;
          free_cnt_nxt = free_cnt_r + 1'b1;
          res_load     = 1'b1;
          res_word     = value_rd_r;
        end
      end
      S_POP_FIX: begin
        if (out_free) begin
          link_we    = 1'b1;
          link_waddr = nbr_r;
          link_wdata = link_rd_r ^ node_r;
          if (at_head_r) head_nxt = nbr_r;
          else           tail_nxt = nbr_r;
          stk_we       = 1'b1;
          free_cnt_nxt = free_cnt_r + 1'b1;
          res_load     = 1'b1;
          res_word     = value_rd_r;
        end
      end
      default: ;
    endcase
  end

  assign res_left = SLOT_W'(SLOTS - 1) - free_cnt_nxt;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      free_cnt_r <= SLOT_W'(SLOTS - 1);
      for (int i = 0; i < SLOTS - 1; i++) begin
        free_stk_r[i] <= SLOT_W'(SLOTS - 1 - i);
      end
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      free_cnt_r <= free_cnt_nxt;
      if (stk_we) free_stk_r[stk_waddr] <= stk_wdata;
    end
  end

  // working registers of the current request
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    nbr_r     <= nbr_nxt;
    at_head_r <= at_head_nxt;
  end

  // link memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (link_re) link_rd_r <= link_mem[link_raddr];
  end

  // value memory: single port
  always_ff @(posedge clk) begin
    if (val_we) value_mem[val_addr] <= q_item.word;
    if (val_re) value_rd_r <= value_mem[val_addr];
  end

  // result register, parts the back end from the output side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r   <= DATA_W'(res_word);
      out_status_r <= res_status;
      out_empty_r  <= (head_nxt == '0);
      out_count_r  <= COUNT_W'(res_left);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_count_r, out_empty_r, out_data_r};
  assign out_tuser  = out_status_r;

endmodule

>>> hdl/xld_checker.sv
// Port-level checks on the deque top level, bound in below.
// Depends on xld_pkg and xor_linked_deque_top_defines.svh.
`timescale 1ns / 1ps
`include "xor_linked_deque_top_defines.svh"

module xld_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [xld_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [xld_pkg::MODE_W-1:0]      in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [xld_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [xld_pkg::STATUS_W-1:0]    out_tuser
);
  import xld_pkg::*;

  logic               res_empty;
  logic [COUNT_W-1:0] res_count;
  logic [DATA_W-1:0]  res_word;
  logic               out_stall;
  logic               pop_empty;
  logic               push_full;

  assign res_empty = out_tdata[OUT_EMPTY_BIT];
  assign res_count = out_tdata[OUT_COUNT_MSB:OUT_COUNT_LSB];
  assign res_word  = out_tdata[DATA_W-1:0];
  assign out_stall = out_tvalid && !out_tready;
  assign pop_empty = out_tvalid && (out_tuser == ST_EMPTY);
  assign push_full = out_tvalid && (out_tuser == ST_FULL);

  // a stalled result holds
  `XLD_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_tdata) && $stable(out_tuser))

  // empty flag agrees with the count
  `XLD_ASSERT_NOW(a_empty_count, out_tvalid, res_empty == (res_count == '0))

  // a pop on an empty list leaves it empty and returns no word
  `XLD_ASSERT_NOW(a_pop_empty, pop_empty, res_empty && (res_word == '0))

  // a full report only with every slot in use
  `XLD_ASSERT_NOW(a_full_count, push_full, res_count == COUNT_W'(SLOTS - 1) && !res_empty)

endmodule

bind xor_linked_deque_top xld_checker u_xld_checker (.*);
